// ===== hdl/sorted_key_value_table_core_defines.svh =====
// Assertion macros for the sorted key-value table core.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle.
`define SKV_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");
// Check that a condition implies a consequence in the following cycle.
`define SKV_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`endif

// ===== hdl/skvt_pkg.sv =====
// Package with types, constants and the key compare for the sorted key-value table.
package skvt_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int VALUE_PORT_WIDTH = 32;
  localparam int KEY_WIDTH = 64;
  localparam int POS_WIDTH = 6;
  localparam int COUNT_PORT_WIDTH = 7;

  typedef enum logic [1:0] {
    CMD_FIND = 2'd0,
    CMD_SET = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_READ_WAIT,
    S_COMPARE,
    S_DECIDE,
    S_SHIFT_READ,
    S_SHIFT_WAIT,
    S_SHIFT_WRITE,
    S_WRITE,
    S_POS_WAIT,
    S_POS_DONE,
    S_DONE
  } state_t;

  // Ordering: -1 before, 0 equal, +1 after, as two flags.
  typedef struct packed {
    logic less;
    logic equal;
  } order_t;

  function automatic order_t order_keys(logic ka, logic [KEY_WIDTH-1:0] kb,
                                        logic sk, logic [KEY_WIDTH-1:0] sb);
    order_t r;
    logic [KEY_WIDTH-1:0] a;
    logic [KEY_WIDTH-1:0] b;
    a = kb;
    b = sb;
    if (!ka) begin
      a[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
      b[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
    end
    if (ka != sk) begin
      r.less = ~ka;
      r.equal = 1'b0;
    end else begin
      r.less = (a < b);
      r.equal = (a == b);
    end
    return r;
  endfunction
endpackage

// ===== hdl/skvt_if.sv =====
// Valid-ready channel interfaces for commands and results.
interface skvt_cmd_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic key_kind;
  logic [skvt_pkg::KEY_WIDTH-1:0] key_bits;
  logic [skvt_pkg::VALUE_PORT_WIDTH-1:0] value_in;
  logic [skvt_pkg::POS_WIDTH-1:0] position;
  modport source (output valid, command, key_kind, key_bits, value_in, position,
                  input ready);
  modport sink (input valid, command, key_kind, key_bits, value_in, position,
                output ready);
endinterface

interface skvt_res_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [skvt_pkg::VALUE_PORT_WIDTH-1:0] value_out;
  logic key_kind_out;
  logic [skvt_pkg::KEY_WIDTH-1:0] key_bits_out;
  logic [skvt_pkg::COUNT_PORT_WIDTH-1:0] entry_count;
  modport source (output valid, status, value_out, key_kind_out, key_bits_out,
                  entry_count, input ready);
  modport sink (input valid, status, value_out, key_kind_out, key_bits_out,
                entry_count, output ready);
endinterface

// ===== hdl/skvt_mem.sv =====
// Entry memory: one write port and one registered read port.
module skvt_mem #(
  parameter int CAPACITY = skvt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int DW = 1 + skvt_pkg::KEY_WIDTH + VALUE_WIDTH
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/sorted_key_value_table_core.sv =====
// Top level of the sorted key-value table: sequencer, compare unit and result register.
// Usage:
//   Commands enter on the cmd channel (find, set, delete, read at position);
//   one result per command leaves on the res channel with status, value,
//   key read at position and the entry count after the command.
//   cmd.ready is high only while the block is idle; one command is worked
//   at a time. Entries live in a memory with one write port and a registered read.
// Sequence:
//   Find: each binary-search step (up to log2(CAPACITY)+1 steps) passes search,
//   read wait, compare and decide; a hit adds the position-done state. Set/delete
//   move one entry per shift read, wait and write, up to CAPACITY-1 entries;
//   a set adds one write. Read at position passes position wait and done.
// Reset:
//   rst clears the entry count and sequencer; memory contents are not cleared,
//   no clearing pass is needed since only entries below the count are read.
// Stall:
//   A result is held in its register until res.ready; the next command is
//   taken only after the result has been taken.
`include "sorted_key_value_table_core_defines.svh"
module sorted_key_value_table_core #(
  parameter int CAPACITY = skvt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  skvt_cmd_if.sink cmd,
  skvt_res_if.source res
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = skvt_pkg::KEY_WIDTH;
  localparam int DW = 1 + KW + VALUE_WIDTH;
  localparam int VPW = skvt_pkg::VALUE_PORT_WIDTH;

  skvt_pkg::state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] lo, hi, ptr;
  logic hit;
  logic [1:0] cmd_r;
  logic ka_r;
  logic [KW-1:0] kb_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [skvt_pkg::POS_WIDTH-1:0] pos_r;
  skvt_pkg::order_t ord;
  logic ord_valid;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [CW-1:0] mid;
  logic [CW:0] mid_sum;
  logic [VALUE_WIDTH-1:0] val_in_w;

  skvt_pkg::status_t status_next;
  logic [VPW-1:0] value_next;
  logic key_kind_next;
  logic [KW-1:0] key_bits_next;

  skvt_mem #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[CW:1];

  generate
    if (VALUE_WIDTH >= VPW) begin : g_vw
      assign val_in_w = VALUE_WIDTH'(cmd.value_in);
    end else begin : g_vn
      assign val_in_w = cmd.value_in[VALUE_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (state == skvt_pkg::S_COMPARE) begin
      ord <= skvt_pkg::order_keys(ka_r, kb_r, rdata[DW-1], rdata[DW-2 -: KW]);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      skvt_pkg::S_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.command == skvt_pkg::CMD_READ) ? skvt_pkg::S_POS_WAIT
                                                           : skvt_pkg::S_SEARCH;
        end
      end
      skvt_pkg::S_SEARCH:
        state_next = (lo < hi) ? skvt_pkg::S_READ_WAIT : skvt_pkg::S_DECIDE;
      skvt_pkg::S_READ_WAIT: state_next = skvt_pkg::S_COMPARE;
      skvt_pkg::S_COMPARE: state_next = skvt_pkg::S_DECIDE;
      skvt_pkg::S_DECIDE: begin
        if (!hit && lo < hi) begin
          state_next = skvt_pkg::S_SEARCH;
        end else begin
          unique case (skvt_pkg::cmd_t'(cmd_r))
            skvt_pkg::CMD_SET: begin
              if (hit) state_next = skvt_pkg::S_WRITE;
              else if (count >= CW'(CAPACITY)) state_next = skvt_pkg::S_DONE;
              else if (ptr > lo) state_next = skvt_pkg::S_SHIFT_READ;
              else state_next = skvt_pkg::S_WRITE;
            end
            skvt_pkg::CMD_DELETE: begin
              if (hit && ptr + CW'(1) < count) state_next = skvt_pkg::S_SHIFT_READ;
              else state_next = skvt_pkg::S_DONE;
            end
            default: state_next = hit ? skvt_pkg::S_POS_DONE : skvt_pkg::S_DONE;
          endcase
        end
      end
      skvt_pkg::S_SHIFT_READ: state_next = skvt_pkg::S_SHIFT_WAIT;
      skvt_pkg::S_SHIFT_WAIT: state_next = skvt_pkg::S_SHIFT_WRITE;
      skvt_pkg::S_SHIFT_WRITE: begin
        if (cmd_r == skvt_pkg::CMD_SET) begin
          state_next = (ptr - CW'(1) > lo) ? skvt_pkg::S_SHIFT_READ : skvt_pkg::S_WRITE;
        end else begin
          state_next = (ptr + CW'(2) < count) ? skvt_pkg::S_SHIFT_READ : skvt_pkg::S_DONE;
        end
      end
      skvt_pkg::S_WRITE: state_next = skvt_pkg::S_DONE;
      skvt_pkg::S_POS_WAIT: state_next = skvt_pkg::S_POS_DONE;
      skvt_pkg::S_POS_DONE: state_next = skvt_pkg::S_DONE;
      skvt_pkg::S_DONE: if (res.ready) state_next = skvt_pkg::S_IDLE;
      default: state_next = skvt_pkg::S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = rdata;
    raddr = mid[AW-1:0];
    unique case (state)
      skvt_pkg::S_IDLE: raddr = AW'(cmd.position);
      skvt_pkg::S_DECIDE, skvt_pkg::S_READ_WAIT, skvt_pkg::S_COMPARE: begin
        raddr = hit ? ptr[AW-1:0] : mid[AW-1:0];
      end
      skvt_pkg::S_SHIFT_READ, skvt_pkg::S_SHIFT_WAIT: begin
        raddr = (cmd_r == skvt_pkg::CMD_SET) ? AW'(ptr - CW'(1)) : AW'(ptr + CW'(1));
      end
      skvt_pkg::S_SHIFT_WRITE: begin
        we = 1'b1;
        wdata = rdata;
      end
      skvt_pkg::S_WRITE: begin
        we = 1'b1;
        waddr = hit ? ptr[AW-1:0] : lo[AW-1:0];
        wdata = hit ? {rdata[DW-1 -: 1 + KW], val_r} : {ka_r, kb_r, val_r};
      end
      skvt_pkg::S_POS_WAIT: raddr = AW'(pos_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skvt_pkg::S_IDLE;
      count <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == skvt_pkg::S_DONE && res.ready) res.valid <= 1'b0;
      if (state_next == skvt_pkg::S_DONE && state != skvt_pkg::S_DONE) res.valid <= 1'b1;
      if (state == skvt_pkg::S_WRITE && !hit) count <= count + CW'(1);
      if (state == skvt_pkg::S_DECIDE && state_next == skvt_pkg::S_DONE &&
          cmd_r == skvt_pkg::CMD_DELETE && hit) count <= count - CW'(1);
      if (state == skvt_pkg::S_SHIFT_WRITE && state_next == skvt_pkg::S_DONE) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      skvt_pkg::S_IDLE: begin
        cmd_r <= cmd.command;
        ka_r <= cmd.key_kind;
        kb_r <= cmd.key_bits;
        val_r <= val_in_w;
        pos_r <= cmd.position;
        lo <= '0;
        hi <= count;
        hit <= 1'b0;
        ptr <= count;
      end
      skvt_pkg::S_SHIFT_WRITE: begin
        ptr <= (cmd_r == skvt_pkg::CMD_SET) ? ptr - CW'(1) : ptr + CW'(1);
      end
      default: ;
    endcase
    // Apply one compare result per step.
    if (state == skvt_pkg::S_DECIDE && !hit && lo < hi && ord_valid) begin
      if (!ord.less && !ord.equal) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
        if (ord.equal) begin
          hit <= 1'b1;
          ptr <= mid;
          lo <= mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ord_valid <= 1'b0;
    else ord_valid <= (state == skvt_pkg::S_COMPARE);
  end

  // Result fields.
  always_comb begin
    status_next = skvt_pkg::ST_OK;
    value_next = '0;
    key_kind_next = 1'b0;
    key_bits_next = '0;
    unique case (skvt_pkg::cmd_t'(cmd_r))
      skvt_pkg::CMD_FIND: begin
        if (hit) value_next = VPW'(rdata[VALUE_WIDTH-1:0]);
        else status_next = skvt_pkg::ST_NOT_FOUND;
      end
      skvt_pkg::CMD_SET: begin
        if (!hit && state == skvt_pkg::S_DECIDE) status_next = skvt_pkg::ST_FULL;
      end
      skvt_pkg::CMD_DELETE: begin
        if (!hit) status_next = skvt_pkg::ST_NOT_FOUND;
      end
      skvt_pkg::CMD_READ: begin
        if (32'(pos_r) < 32'(count)) begin
          value_next = VPW'(rdata[VALUE_WIDTH-1:0]);
          key_kind_next = rdata[DW-1];
          key_bits_next = rdata[DW-2 -: KW];
        end else begin
          status_next = skvt_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state != skvt_pkg::S_DONE && state_next == skvt_pkg::S_DONE) begin
      res.status <= status_next;
      res.value_out <= value_next;
      res.key_kind_out <= key_kind_next;
      res.key_bits_out <= key_bits_next;
    end
  end

  always_comb begin
    res.entry_count = skvt_pkg::COUNT_PORT_WIDTH'(count);
  end

  assign cmd.ready = (state == skvt_pkg::S_IDLE);

  `SKV_ASSERT_IMPLY(a_count_max, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `SKV_ASSERT_IMPLY(a_ready_idle, clk, rst, res.valid, !cmd.ready)
  `SKV_ASSERT_NEXT(a_valid_hold, clk, rst, res.valid && !res.ready, res.valid)
endmodule
